// ===== hw/rtl/pidpd_pkg.sv =====
// Shared types, constants and helper functions for the PID controller core.
`default_nettype none
package pidpd_pkg;

  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 48;
  localparam int QUO_W   = 16;
  localparam int LIM_W   = 31;

  typedef enum logic [2:0] {
    REG_LOOP_MODE  = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_OUT_LIMIT  = 3'd4,
    REG_INT_LIMIT  = 3'd5,
    REG_SEP_THRESH = 3'd6,
    REG_DEAD_BAND  = 3'd7
  } reg_e;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_ERR1 = 9'b000000010,
    ST_ERR2 = 9'b000000100,
    ST_PREP = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_MUL  = 9'b000100000,
    ST_ACC  = 9'b001000000,
    ST_SUM  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [LIM_W-1:0] num;
    logic [LIM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] val;
  } clamp_t;

  function automatic clamp_t clamp_sym(input logic signed [63:0] x,
                                       input logic [LIM_W-1:0] lim);
    clamp_t r;
    logic signed [63:0] pl;
    pl = 64'(signed'({1'b0, lim}));
    r.hit = 1'b0;
    r.val = 32'(x);
    if (x > pl) begin
      r.hit = 1'b1;
      r.val = 32'(pl);
    end else if (x < -pl) begin
      r.hit = 1'b1;
      r.val = 32'(-pl);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    r = 32'(x);
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pidpd_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none
module pidpd_mul (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic signed [pidpd_pkg::MUL_A_W-1:0]   a_i,
  input  wire logic signed [pidpd_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [pidpd_pkg::PROD_W-1:0]         prod_o
);

  logic signed [pidpd_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= pidpd_pkg::PROD_W'(a_i) * pidpd_pkg::PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pidpd_div.sv =====
// Restoring divider, one quotient bit per cycle, for num < den.
`default_nettype none
module pidpd_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire pidpd_pkg::div_req_t        req_i,
  output logic                            done_o,
  output logic [pidpd_pkg::QUO_W-1:0]     quo_o
);

  logic [31:0]                   rem_q;
  logic [pidpd_pkg::LIM_W-1:0]   den_q;
  logic [pidpd_pkg::QUO_W-1:0]   quo_q;
  logic [4:0]                    cnt_q;
  logic                          busy_q, done_q;
  logic [31:0]                   rem2;
  logic                          ge;

  assign rem2 = {rem_q[30:0], 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(pidpd_pkg::QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.num};
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem2 - {1'b0, den_q} : rem2;
      quo_q <= {quo_q[pidpd_pkg::QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pid_controller_pos_delta_core.sv =====
// Top level of the positional / incremental PID controller core.
// Input stream: one word per sample, tdata = {feedback, setpoint}, Q16.16.
// Output stream: one word per sample, tdata = drive value, tuser = saturation flag.
// The user must write registers over the APB port only while the core is
// idle; the core does not enforce this. Each sample runs through a sequencer
// that drives one shared multiplier: two error conditioning states, a setup
// state, alternating multiply and accumulate states for each operation,
// a sum state and an output state, then the idle state before the next word is taken.
// In incremental mode a scale factor that needs a division first runs
// through the bit-serial divider in the divide state.
// s_axis_tready is high only between samples.
// The result sits in an output register; the next sample is accepted while
// it waits, but that sample stalls in the output state until the receiver
// takes the previous word.
// Reset clears the controller history and loads register defaults.
`default_nettype none
module pid_controller_pos_delta_core #(
  parameter int DERIV_FILTER = 0,
  parameter int ANGLE_SPAN   = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] setpoint, [63:32] feedback
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] drive_out
  output logic [0:0]       m_axis_tuser,   // [0] out_saturated
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = pidpd_pkg::MUL_A_W;
  localparam int BW = pidpd_pkg::MUL_B_W;
  localparam int PW = pidpd_pkg::PROD_W;
  localparam int CW = pidpd_pkg::ACC_W;
  localparam logic signed [33:0] SPAN = 34'(ANGLE_SPAN * 65536);
  localparam logic signed [33:0] HALF = 34'((ANGLE_SPAN / 2) * 65536);
  localparam logic signed [BW-1:0] FILT_G = BW'(DERIV_FILTER);
  localparam logic signed [BW-1:0] FILT_M = BW'(65536 - DERIV_FILTER);

  pidpd_pkg::state_e state_q;

  logic               loop_mode_q;
  logic signed [23:0] gain_p_q, gain_i_q, gain_d_q;
  logic [30:0]        out_lim_q, int_lim_q, sep_q, dead_q;

  logic signed [31:0] sp_q, fb_q, e_q, prev_q, pp_q, integ_q, ld_q, oacc_q;
  logic signed [33:0] ew_q;
  logic [31:0]        ae_q;
  logic [16:0]        f_q;
  logic [2:0]         op_q;
  logic signed [CW-1:0] res_q, d_q;
  logic signed [PW-1:0] t_q, frac_q;
  logic [31:0]        out_data_q;
  logic               out_sat_q, out_valid_q;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod, prod_shr;
  logic signed [32:0]   e_m_p, e_p_p;
  logic signed [34:0]   e_2d;
  logic signed [33:0]   diff, wrapped;
  logic signed [31:0]   es;
  logic [32:0]          es_abs;
  logic [2:0]           last_op;
  logic                 need_div, div_done, use_i;
  logic                 out_load;
  logic [pidpd_pkg::QUO_W-1:0] quo;
  pidpd_pkg::div_req_t  div_req;
  pidpd_pkg::clamp_t    int_pos, int_inc, out_cl;
  logic signed [63:0]   inc_sum;
  pidpd_pkg::reg_e      rsel;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign rsel   = pidpd_pkg::reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_mode_q <= 1'b0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      out_lim_q   <= 31'h7fffffff;
      int_lim_q   <= 31'h7fffffff;
      sep_q       <= 31'h7fffffff;
      dead_q      <= '0;
    end else if (psel && penable && pwrite) begin
      case (rsel)
        pidpd_pkg::REG_LOOP_MODE:  loop_mode_q <= pwdata[0];
        pidpd_pkg::REG_GAIN_P:     gain_p_q    <= pwdata[23:0];
        pidpd_pkg::REG_GAIN_I:     gain_i_q    <= pwdata[23:0];
        pidpd_pkg::REG_GAIN_D:     gain_d_q    <= pwdata[23:0];
        pidpd_pkg::REG_OUT_LIMIT:  out_lim_q   <= pwdata[30:0];
        pidpd_pkg::REG_INT_LIMIT:  int_lim_q   <= pwdata[30:0];
        pidpd_pkg::REG_SEP_THRESH: sep_q       <= pwdata[30:0];
        pidpd_pkg::REG_DEAD_BAND:  dead_q      <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (rsel)
      pidpd_pkg::REG_LOOP_MODE:  prdata = {31'd0, loop_mode_q};
      pidpd_pkg::REG_GAIN_P:     prdata = 32'(gain_p_q);
      pidpd_pkg::REG_GAIN_I:     prdata = 32'(gain_i_q);
      pidpd_pkg::REG_GAIN_D:     prdata = 32'(gain_d_q);
      pidpd_pkg::REG_OUT_LIMIT:  prdata = {1'b0, out_lim_q};
      pidpd_pkg::REG_INT_LIMIT:  prdata = {1'b0, int_lim_q};
      pidpd_pkg::REG_SEP_THRESH: prdata = {1'b0, sep_q};
      pidpd_pkg::REG_DEAD_BAND:  prdata = {1'b0, dead_q};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  assign diff = 34'(sp_q) - 34'(fb_q);
  always_comb begin
    wrapped = diff;
    if (ANGLE_SPAN != 0) begin
      if (diff > HALF) begin
        wrapped = diff - SPAN;
      end else if (diff < -HALF) begin
        wrapped = diff + SPAN;
      end
    end
  end

  assign es     = pidpd_pkg::sat32(64'(ew_q));
  assign es_abs = es[31] ? -33'(es) : 33'(es);

  assign e_m_p = 33'(e_q) - 33'(prev_q);
  assign e_p_p = 33'(e_q) + 33'(prev_q);
  assign e_2d  = 35'(e_q) - (35'(prev_q) <<< 1) + 35'(pp_q);

  assign last_op  = loop_mode_q ? 3'd4 : 3'd5;
  assign need_div = loop_mode_q && (ae_q != 32'd0) && (ae_q <= {1'b0, sep_q});
  assign use_i    = loop_mode_q || (ae_q <= {1'b0, sep_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (!loop_mode_q) begin
      case (op_q)
        3'd0: begin mul_a = AW'(e_q);   mul_b = BW'(gain_p_q); end
        3'd1: begin mul_a = AW'(e_q);   mul_b = BW'(gain_i_q); end
        3'd2: begin mul_a = AW'(e_m_p); mul_b = BW'(gain_d_q); end
        3'd3: begin mul_a = AW'(t_q >>> 16);          mul_b = FILT_M; end
        3'd4: begin mul_a = AW'({1'b0, t_q[15:0]});  mul_b = FILT_M; end
        3'd5: begin mul_a = AW'(ld_q);  mul_b = FILT_G; end
        default: ;
      endcase
    end else begin
      case (op_q)
        3'd0: begin mul_a = AW'(e_m_p); mul_b = BW'(gain_p_q); end
        3'd1: begin mul_a = AW'(e_p_p); mul_b = BW'(gain_i_q); end
        3'd2: begin mul_a = AW'(t_q >>> 16);          mul_b = BW'({1'b0, f_q}); end
        3'd3: begin mul_a = AW'({1'b0, t_q[15:0]});  mul_b = BW'({1'b0, f_q}); end
        3'd4: begin mul_a = AW'(e_2d);  mul_b = BW'(gain_d_q); end
        default: ;
      endcase
    end
  end

  pidpd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (state_q == pidpd_pkg::ST_MUL),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign prod_shr = prod >>> 16;
  assign int_pos  = pidpd_pkg::clamp_sym(64'(integ_q) + 64'(prod_shr), int_lim_q);
  assign inc_sum  = ((64'(frac_q) <<< 16) + 64'(prod)) >>> 17;
  assign int_inc  = pidpd_pkg::clamp_sym(inc_sum, int_lim_q);
  assign out_cl   = pidpd_pkg::clamp_sym(64'(res_q), out_lim_q);

  assign div_req.start = (state_q == pidpd_pkg::ST_PREP) && need_div;
  assign div_req.num   = sep_q - ae_q[30:0];
  assign div_req.den   = sep_q;

  pidpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign out_load = (state_q == pidpd_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pidpd_pkg::ST_IDLE;
      op_q        <= '0;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      pp_q        <= '0;
      integ_q     <= '0;
      ld_q        <= '0;
      oacc_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        pidpd_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= pidpd_pkg::ST_ERR1;
          end
        end
        pidpd_pkg::ST_ERR1: state_q <= pidpd_pkg::ST_ERR2;
        pidpd_pkg::ST_ERR2: begin
          if (es_abs < {2'b0, dead_q}) begin
            prev_q <= '0;
          end
          state_q <= pidpd_pkg::ST_PREP;
        end
        pidpd_pkg::ST_PREP: begin
          op_q    <= '0;
          state_q <= need_div ? pidpd_pkg::ST_DIV : pidpd_pkg::ST_MUL;
        end
        pidpd_pkg::ST_DIV: begin
          if (div_done) begin
            state_q <= pidpd_pkg::ST_MUL;
          end
        end
        pidpd_pkg::ST_MUL: state_q <= pidpd_pkg::ST_ACC;
        pidpd_pkg::ST_ACC: begin
          if (!loop_mode_q && op_q == 3'd1) begin
            integ_q <= int_pos.val;
          end
          if (loop_mode_q && op_q == 3'd3) begin
            integ_q <= int_inc.val;
          end
          if (op_q == last_op) begin
            state_q <= pidpd_pkg::ST_SUM;
          end else begin
            op_q    <= op_q + 3'd1;
            state_q <= pidpd_pkg::ST_MUL;
          end
        end
        pidpd_pkg::ST_SUM: state_q <= pidpd_pkg::ST_OUT;
        pidpd_pkg::ST_OUT: begin
          if (out_load) begin
            oacc_q      <= out_cl.val;
            ld_q        <= pidpd_pkg::sat32(64'(d_q));
            pp_q        <= prev_q;
            prev_q      <= e_q;
            state_q     <= pidpd_pkg::ST_IDLE;
          end
        end
        default: state_q <= pidpd_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      pidpd_pkg::ST_IDLE: begin
        sp_q <= s_axis_tdata[31:0];
        fb_q <= s_axis_tdata[63:32];
      end
      pidpd_pkg::ST_ERR1: ew_q <= wrapped;
      pidpd_pkg::ST_ERR2: begin
        if (es_abs < {2'b0, dead_q}) begin
          e_q  <= '0;
          ae_q <= '0;
        end else begin
          e_q  <= es;
          ae_q <= es_abs[31:0];
        end
      end
      pidpd_pkg::ST_PREP: f_q <= (ae_q == 32'd0) ? 17'h10000 : 17'd0;
      pidpd_pkg::ST_DIV: begin
        if (div_done) begin
          f_q <= {1'b0, quo};
        end
      end
      pidpd_pkg::ST_ACC: begin
        if (!loop_mode_q) begin
          case (op_q)
            3'd0: res_q  <= CW'(prod_shr);
            3'd2: t_q    <= prod_shr;
            3'd3: d_q    <= CW'(prod);
            3'd4: frac_q <= prod;
            3'd5: d_q    <= d_q + CW'((frac_q + prod) >>> 16);
            default: ;
          endcase
        end else begin
          case (op_q)
            3'd0: res_q  <= CW'(oacc_q) + CW'(prod_shr);
            3'd1: t_q    <= prod_shr;
            3'd2: frac_q <= prod;
            3'd4: d_q    <= CW'(prod_shr);
            default: ;
          endcase
        end
      end
      pidpd_pkg::ST_SUM: res_q <= res_q + d_q + (use_i ? CW'(integ_q) : CW'(0));
      pidpd_pkg::ST_OUT: begin
        if (out_load) begin
          out_data_q <= out_cl.val;
          out_sat_q  <= out_cl.hit;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready   = (state_q == pidpd_pkg::ST_IDLE);
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_sat_q;

  // ---------------- assertions ----------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == pidpd_pkg::ST_ERR1))
    else $error("accepted word did not start the sequencer");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == pidpd_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_op_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pidpd_pkg::ST_ACC) |-> (op_q <= last_op))
    else $error("operation index past last multiply");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == pidpd_pkg::ST_OUT))
    else $error("output word raised outside the output state");

endmodule
`default_nettype wire
